// ----- src/assert_macros.svh -----
// assertion macros used by the file that checks this block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every rising clock edge outside reset
`define IM_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent that must hold on the clock after the antecedent
`define IM_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/im_pkg.sv -----
// shared types and helpers of the interval merge unit
package im_pkg;

	// controller states
	typedef enum logic [1:0] {
		ST_LOAD,
		ST_START,
		ST_SWEEP
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic insert;
		logic set_ovf;
		logic take_head;
		logic merge_head;
		logic emit;
		logic emit_last;
		logic clear;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic full;
		logic cnt_zero;
		logic head_le;
		logic out_free;
	} status_t;

	// ordering by start, then by end, signed
	function automatic logic key_before(
		input logic signed [31:0] s1,
		input logic signed [31:0] e1,
		input logic signed [31:0] s2,
		input logic signed [31:0] e2
	);
		logic r;
		if (s1 != s2) begin
			r = s1 < s2;
		end else begin
			r = e1 < e2;
		end
		return r;
	endfunction

endpackage

// ----- src/im_ctrl.sv -----
// controller state machine: load, then sweep the sorted chain and emit
module im_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	output logic              in_ready,
	input  im_pkg::status_t   st,
	output im_pkg::cmd_t      cmd
);

	im_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= im_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			im_pkg::ST_LOAD: begin
				if (in_valid && in_last) begin
					state_d = im_pkg::ST_START;
				end
			end
			im_pkg::ST_START: begin
				state_d = im_pkg::ST_SWEEP;
			end
			im_pkg::ST_SWEEP: begin
				if (st.cnt_zero && st.out_free) begin
					state_d = im_pkg::ST_LOAD;
				end
			end
			default: begin
				state_d = im_pkg::ST_LOAD;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			im_pkg::ST_LOAD: begin
				in_ready = 1'b1;
				cmd.insert = in_valid && !st.full;
				cmd.set_ovf = in_valid && st.full;
			end
			im_pkg::ST_START: begin
				cmd.take_head = 1'b1;
			end
			im_pkg::ST_SWEEP: begin
				priority if (st.cnt_zero) begin
					// group still open is the final one
					cmd.emit = st.out_free;
					cmd.emit_last = st.out_free;
					cmd.clear = st.out_free;
				end else if (st.head_le) begin
					cmd.merge_head = 1'b1;
				end else begin
					// close group and open a new one with the head
					cmd.emit = st.out_free;
					cmd.take_head = st.out_free;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ----- src/im_dp.sv -----
// datapath: sorted insertion chain, merge registers and output register
module im_dp #(
	parameter int MAX_INTERVALS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [31:0] in_start,
	input  logic signed [31:0] in_end,
	input  im_pkg::cmd_t       cmd,
	output im_pkg::status_t    st,
	input  logic               out_ready,
	output logic               out_valid,
	output logic signed [31:0] out_start,
	output logic signed [31:0] out_end,
	output logic               out_last,
	output logic               out_dropped
);

	localparam int CW = $clog2(MAX_INTERVALS + 1);

	logic signed [31:0] start_q [MAX_INTERVALS];
	logic signed [31:0] end_q   [MAX_INTERVALS];
	logic [MAX_INTERVALS-1:0] lt;
	logic [CW-1:0]      count_q;
	logic               ovf_q;
	logic signed [31:0] cs_q, ce_q;
	logic               out_valid_q, out_last_q, out_drop_q;
	logic signed [31:0] out_start_q, out_end_q;
	logic               shift;

	assign shift = cmd.take_head || cmd.merge_head;

	// per cell: new beat sorts before this cell, or the cell is empty
	always_comb begin
		for (int i = 0; i < MAX_INTERVALS; i++) begin
			lt[i] = (CW'(i) >= count_q) ||
				im_pkg::key_before(in_start, in_end, start_q[i], end_q[i]);
		end
	end

	// sorted chain: insert moves larger cells up, shift moves the cells down toward the head
	for (genvar g = 0; g < MAX_INTERVALS; g++) begin : g_cell
		always_ff @(posedge clk) begin
			if (cmd.insert) begin
				if (lt[g]) begin
					if (g > 0 && lt[(g > 0) ? g - 1 : 0]) begin
						start_q[g] <= start_q[(g > 0) ? g - 1 : 0];
						end_q[g]   <= end_q[(g > 0) ? g - 1 : 0];
					end else begin
						start_q[g] <= in_start;
						end_q[g]   <= in_end;
					end
				end
			end else if (shift && g < MAX_INTERVALS - 1) begin
				start_q[g] <= start_q[(g < MAX_INTERVALS - 1) ? g + 1 : g];
				end_q[g]   <= end_q[(g < MAX_INTERVALS - 1) ? g + 1 : g];
			end
		end
	end

	// fill count and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.insert) begin
				count_q <= count_q + CW'(1);
			end else if (shift) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.clear) begin
				ovf_q <= 1'b0;
			end else if (cmd.set_ovf) begin
				ovf_q <= 1'b1;
			end
		end
	end

	// running group bounds
	always_ff @(posedge clk) begin
		if (cmd.take_head) begin
			cs_q <= start_q[0];
			ce_q <= end_q[0];
		end else if (cmd.merge_head && end_q[0] > ce_q) begin
			ce_q <= end_q[0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_start_q <= cs_q;
			out_end_q   <= ce_q;
			out_last_q  <= cmd.emit_last;
			out_drop_q  <= ovf_q;
		end
	end

	// status
	always_comb begin
		st.full     = count_q == CW'(MAX_INTERVALS);
		st.cnt_zero = count_q == '0;
		st.head_le  = start_q[0] <= ce_q;
		st.out_free = !out_valid_q || out_ready;
	end

	assign out_valid   = out_valid_q;
	assign out_start   = out_start_q;
	assign out_end     = out_end_q;
	assign out_last    = out_last_q;
	assign out_dropped = out_drop_q;

endmodule

// ----- src/interval_merge_unit.sv -----
// top level of the interval merge unit
// Loads a set of signed intervals, one beat per cycle, into a sorted
// insertion chain of MAX_INTERVALS cells; beats past capacity are dropped
// and flagged on tuser of every result of the set. The beat with tlast
// ends the set: the chain is then shifted out head first, one cell per
// cycle while the output side does not stall, and overlapping or touching
// intervals fold into one group. Input is not taken during the sweep.
// The result register lets the next set load while the last result waits.
`include "assert_macros.svh"

module interval_merge_unit #(
	parameter int MAX_INTERVALS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // interval_start [31:0], interval_end [63:32]
	input  logic        s_axis_tlast,  // last_interval
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // merged_start [31:0], merged_end [63:32]
	output logic        m_axis_tlast,  // last_merged
	output logic        m_axis_tuser   // dropped
);

	im_pkg::cmd_t       cmd;
	im_pkg::status_t    st;
	logic signed [31:0] merged_start, merged_end;

	// controller
	im_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// datapath
	im_dp #(
		.MAX_INTERVALS (MAX_INTERVALS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_start    (s_axis_tdata[31:0]),
		.in_end      (s_axis_tdata[63:32]),
		.cmd         (cmd),
		.st          (st),
		.out_ready   (m_axis_tready),
		.out_valid   (m_axis_tvalid),
		.out_start   (merged_start),
		.out_end     (merged_end),
		.out_last    (m_axis_tlast),
		.out_dropped (m_axis_tuser)
	);

	assign m_axis_tdata = {merged_end, merged_start};

	// checks
	`IM_ASSERT(a_emit_room, !cmd.emit || st.out_free, "result emitted over a pending result")
	`IM_ASSERT(a_no_insert_full, !(cmd.insert && st.full), "insert into a full chain")
	`IM_ASSERT(a_shift_nonempty, !(cmd.take_head || cmd.merge_head) || !st.cnt_zero, "shift of an empty chain")
	`IM_ASSERT_NEXT(a_emit_valid, cmd.emit, m_axis_tvalid, "emitted result not presented")

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench of the interval merge unit: stream driver, merge predictor, checker
`timescale 1ns / 100ps

module testbench;

	localparam int MAX_IV     = 64;
	localparam int IDLE_LIMIT = 4000;
	localparam int TAIL_WAIT  = 200;
	localparam logic [31:0] INT_MIN = 32'h8000_0000;
	localparam logic [31:0] INT_MAX = 32'h7fff_ffff;

	// point distributions for random intervals
	typedef enum int {
		PT_CLUSTER,
		PT_FULL,
		PT_EXTREME
	} point_mode_t;

	typedef struct {
		logic signed [31:0] mstart;
		logic signed [31:0] mend;
		logic               mlast;
		logic               mdrop;
	} merged_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;   // interval_start [31:0], interval_end [63:32]
	logic        s_axis_tlast = 1'b0; // last_interval
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;        // merged_start [31:0], merged_end [63:32]
	logic        m_axis_tlast;        // last_merged
	logic        m_axis_tuser;        // dropped

	// intervals of the set being loaded, as the block should hold them
	int      load_start[$];
	int      load_end[$];
	bit      load_dropped;
	merged_t merged_q[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	interval_merge_unit #(
		.MAX_INTERVALS(MAX_IV)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// store one interval; on the set end sort, sweep and queue the merged groups
	function automatic void predict_merge(int s, int e, bit last);
		int      ks[MAX_IV];
		int      ke[MAX_IV];
		int      n;
		int      j;
		int      ts;
		int      te;
		int      cs;
		int      ce;
		merged_t r;
		if (load_start.size() < MAX_IV) begin
			load_start.insert(load_start.size(), s);
			load_end.insert(load_end.size(), e);
		end else begin
			load_dropped = 1'b1;
		end
		if (!last) begin
			return;
		end
		n = load_start.size();
		for (int i = 0; i < n; i++) begin
			ts = load_start[i];
			te = load_end[i];
			j = i;
			while (j > 0 && (ts < ks[j-1] || (ts == ks[j-1] && te < ke[j-1]))) begin
				ks[j] = ks[j-1];
				ke[j] = ke[j-1];
				j--;
			end
			ks[j] = ts;
			ke[j] = te;
		end
		cs = ks[0];
		ce = ke[0];
		for (int i = 1; i < n; i++) begin
			if (ks[i] <= ce) begin
				if (ke[i] > ce) begin
					ce = ke[i];
				end
			end else begin
				r.mstart = cs;
				r.mend   = ce;
				r.mlast  = 1'b0;
				r.mdrop  = load_dropped;
				merged_q.insert(merged_q.size(), r);
				cs = ks[i];
				ce = ke[i];
			end
		end
		r.mstart = cs;
		r.mend   = ce;
		r.mlast  = 1'b1;
		r.mdrop  = load_dropped;
		merged_q.insert(merged_q.size(), r);
		load_start.delete();
		load_end.delete();
		load_dropped = 1'b0;
	endfunction

	// one input beat; called and returns at a falling edge
	task automatic send_interval(logic [31:0] s, logic [31:0] e, bit last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {e, s};
		s_axis_tlast  <= last;
		do begin
			@(posedge clk);
		end while (s_axis_tready !== 1'b1);
		predict_merge(s, e, last);
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_point(point_mode_t mode, logic [31:0] base);
		logic [31:0] p;
		case (mode)
			PT_CLUSTER: begin
				p = base + $urandom_range(0, 60);
			end
			PT_FULL: begin
				p = $urandom;
			end
			default: begin
				case ($urandom_range(3))
					0: p = INT_MIN + $urandom_range(0, 3);
					1: p = INT_MAX - $urandom_range(0, 3);
					2: p = 32'(-$urandom_range(0, 2));
					default: p = $urandom_range(0, 2);
				endcase
			end
		endcase
		return p;
	endfunction

	// set of n intervals with random content, tlast on the last one
	task automatic send_random_set(int n);
		point_mode_t mode;
		logic [31:0] base;
		logic [31:0] s;
		logic [31:0] e;
		case ($urandom_range(9))
			0, 1: mode = PT_FULL;
			2: mode = PT_EXTREME;
			default: mode = PT_CLUSTER;
		endcase
		base = $urandom;
		for (int i = 0; i < n; i++) begin
			s = pick_point(mode, base);
			if (mode == PT_CLUSTER) begin
				if ($urandom_range(9) == 0) begin
					e = s - $urandom_range(1, 10);
				end else begin
					e = s + $urandom_range(0, 20);
				end
			end else begin
				e = pick_point(mode, base);
			end
			send_interval(s, e, i == n - 1);
		end
	endtask

	// intervals at the extremes of the signed range, most of them as one-interval sets
	task automatic test_extremes();
		send_interval(INT_MIN, INT_MAX, 1'b1);
		send_interval(INT_MAX, INT_MAX, 1'b1);
		send_interval(INT_MIN, INT_MIN, 1'b1);
		send_interval(32'hffff_ffff, 32'h0000_0000, 1'b1);
		send_interval(INT_MIN, INT_MIN, 1'b0);
		send_interval(INT_MAX, INT_MAX, 1'b1);
	endtask

	// touching ends merge, gaps split, unsorted input comes out ordered
	task automatic test_touch_and_gap();
		send_interval(32'd10, 32'd20, 1'b0);
		send_interval(-32'sd5, -32'sd1, 1'b0);
		send_interval(32'd0, 32'd5, 1'b0);
		send_interval(32'd5, 32'd9, 1'b0);
		send_interval(32'd21, 32'd30, 1'b1);
	endtask

	// start above end is taken as given
	task automatic test_inverted();
		send_interval(32'd7, 32'd3, 1'b1);
		send_interval(32'd7, 32'd3, 1'b0);
		send_interval(32'd4, 32'd6, 1'b1);
		send_interval(32'd1, 32'd10, 1'b0);
		send_interval(32'd3, 32'd2, 1'b1);
	endtask

	// equal starts order by end; a contained interval keeps the larger end
	task automatic test_equal_starts();
		send_interval(32'd3, 32'd8, 1'b0);
		send_interval(32'd3, 32'd4, 1'b0);
		send_interval(32'd3, 32'd8, 1'b0);
		send_interval(32'd5, 32'd6, 1'b1);
	endtask

	// exactly full, then beats past capacity including the set end
	task automatic test_capacity();
		logic [31:0] base;
		logic [31:0] s;
		base = $urandom;
		for (int i = 0; i < MAX_IV; i++) begin
			s = base + $urandom_range(0, 400);
			send_interval(s, s + $urandom_range(0, 6), i == MAX_IV - 1);
		end
		for (int i = 0; i < MAX_IV + 1; i++) begin
			s = base + $urandom_range(0, 400);
			send_interval(s, s + $urandom_range(0, 6), i == MAX_IV);
		end
		for (int i = 0; i < MAX_IV + 3; i++) begin
			s = $urandom;
			send_interval(s, $urandom, i == MAX_IV + 2);
		end
		// the drop flag must be clear again on the next set
		send_random_set(2);
	endtask

	// random sets, mostly short, a few mid-sized
	task automatic test_random_sets(int n_items);
		int sent;
		int n;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(9) < 8) begin
				n = $urandom_range(1, 8);
			end else begin
				n = $urandom_range(9, 24);
			end
			send_random_set(n);
			sent += n;
		end
	endtask

	// compare each result beat with the oldest queued group
	always @(posedge clk) begin
		merged_t exp_r;
		if (arst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
			if (merged_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result beat: start %0d end %0d last %b dropped %b",
						$signed(m_axis_tdata[31:0]), $signed(m_axis_tdata[63:32]),
						m_axis_tlast, m_axis_tuser);
				end
			end else begin
				exp_r = merged_q.pop_front();
				if (m_axis_tdata[31:0] !== exp_r.mstart || m_axis_tdata[63:32] !== exp_r.mend
						|| m_axis_tlast !== exp_r.mlast || m_axis_tuser !== exp_r.mdrop) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: exp start %0d end %0d last %b dropped %b",
							exp_r.mstart, exp_r.mend, exp_r.mlast, exp_r.mdrop);
						$display("          got start %0d end %0d last %b dropped %b",
							$signed(m_axis_tdata[31:0]), $signed(m_axis_tdata[63:32]),
							m_axis_tlast, m_axis_tuser);
					end
				end
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1)
				|| (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		load_dropped = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_idle_pct = 14;
		recv_idle_pct = 61;
		test_extremes();
		test_touch_and_gap();
		test_inverted();
		test_equal_starts();
		test_random_sets(40);

		send_idle_pct = 61;
		recv_idle_pct = 14;
		test_random_sets(30);
		test_capacity();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_sets(30);

		s_axis_tvalid <= 1'b0;
		while (merged_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_WAIT) @(posedge clk);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
